@@ design/utn_pkg.sv @@
// Unit triangle normal: shared widths, constants and transaction types.
// No dependencies; imported by every module of the block.
package utn_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int NORMAL_WIDTH     = NORMAL_FRAC_BITS + 2;

    // Edge vectors and cross product
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = CROSS_W - 1;
    localparam int POS_W   = $clog2(MAG_W);

    // The largest normalised magnitude lands in [2^SCALE_TOP, 2^(SCALE_TOP+1))
    localparam int SCALE_TOP = 29;
    localparam int NMAG_W    = SCALE_TOP + 1;
    localparam int SQ_W      = 2 * NMAG_W;
    localparam int SUM_W     = SQ_W + 2;

    // Square root: one result bit per stage
    localparam int ROOT_STEPS = SUM_W / 2;
    localparam int ROOT_W     = ROOT_STEPS;

    // Rounded division: one quotient bit per stage
    localparam int QUO_W  = NORMAL_FRAC_BITS + 1;
    localparam int DIVR_W = ROOT_W + 1;
    localparam int NUM_W  = NMAG_W + QUO_W + 1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_a_x;
        logic signed [COORD_WIDTH-1:0] point_a_y;
        logic signed [COORD_WIDTH-1:0] point_a_z;
        logic signed [COORD_WIDTH-1:0] point_b_x;
        logic signed [COORD_WIDTH-1:0] point_b_y;
        logic signed [COORD_WIDTH-1:0] point_b_z;
        logic signed [COORD_WIDTH-1:0] pivot_x;
        logic signed [COORD_WIDTH-1:0] pivot_y;
        logic signed [COORD_WIDTH-1:0] pivot_z;
    } tri_in_t;

    typedef struct packed {
        logic signed [NORMAL_WIDTH-1:0] normal_x;
        logic signed [NORMAL_WIDTH-1:0] normal_y;
        logic signed [NORMAL_WIDTH-1:0] normal_z;
        logic                           degenerate;
    } tri_out_t;

    // Per-item data that rides alongside the root and divide pipelines
    typedef struct packed {
        logic [2:0][NMAG_W-1:0] mag;
        logic [2:0]             neg;
        logic                   degen;
    } nrm_side_t;

endpackage

@@ design/utn_isqrt.sv @@
// Unit triangle normal: pipelined integer square root, one root bit per stage.
// Depends on utn_pkg.
module utn_isqrt
    import utn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [SUM_W-1:0] in_sum,
    input  nrm_side_t        in_side,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [ROOT_W-1:0] out_root,
    output nrm_side_t        out_side
);

    logic [ROOT_STEPS-1:0] v_reg;
    logic [ROOT_STEPS-1:0] adv;
    logic [SUM_W-1:0]      rem_reg  [ROOT_STEPS];
    logic [SUM_W-1:0]      root_reg [ROOT_STEPS];
    nrm_side_t             side_reg [ROOT_STEPS];
    logic [SUM_W-1:0]      rem_src  [ROOT_STEPS];
    logic [SUM_W-1:0]      root_src [ROOT_STEPS];
    nrm_side_t             side_src [ROOT_STEPS];

    // Stage advances when empty or when the next one takes its transaction
    always_comb
    begin
        adv[ROOT_STEPS-1] = ~v_reg[ROOT_STEPS-1] | out_ready;
        for (int i = ROOT_STEPS - 2; i >= 0; i--)
        begin
            adv[i] = ~v_reg[i] | adv[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < ROOT_STEPS; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= (i == 0) ? in_valid : v_reg[i-1];
                end
            end
        end
    end

    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_step
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
        logic [SUM_W:0]   trial;
        logic [SUM_W-1:0] rem_next;
        logic [SUM_W-1:0] root_next;

        if (k == 0)
        begin : g_first
            assign rem_src[k]  = in_sum;
            assign root_src[k] = '0;
            assign side_src[k] = in_side;
        end
        else
        begin : g_rest
            assign rem_src[k]  = rem_reg[k-1];
            assign root_src[k] = root_reg[k-1];
            assign side_src[k] = side_reg[k-1];
        end

        // Trial subtract of root + bit
        always_comb
        begin
            trial = {1'b0, root_src[k]} + {1'b0, BIT};
            if ({1'b0, rem_src[k]} >= trial)
            begin
                rem_next  = rem_src[k] - trial[SUM_W-1:0];
                root_next = (root_src[k] >> 1) + BIT;
            end
            else
            begin
                rem_next  = rem_src[k];
                root_next = root_src[k] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_src[k];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[ROOT_STEPS-1];
    assign out_root  = root_reg[ROOT_STEPS-1][ROOT_W-1:0];
    assign out_side  = side_reg[ROOT_STEPS-1];

endmodule

@@ design/utn_div.sv @@
// Unit triangle normal: three parallel pipelined restoring dividers giving the
// rounded unit components, plus sign and degenerate handling. Depends on utn_pkg.
module utn_div
    import utn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ROOT_W-1:0] in_root,
    input  nrm_side_t         in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output tri_out_t          out_data
);

    // Prep stage, one stage per quotient bit, then the output stage
    localparam int STAGES = QUO_W + 2;
    localparam int LAST   = STAGES - 1;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] adv;

    logic [DIVR_W-1:0]       dvs_reg  [QUO_W+1];
    logic [2:0][DIVR_W-1:0]  prem_reg [QUO_W+1];
    logic [2:0][QUO_W-1:0]   low_reg  [QUO_W+1];
    logic [2:0][QUO_W-1:0]   quo_reg  [QUO_W+1];
    nrm_side_t               side_reg [QUO_W+1];
    tri_out_t                out_reg;

    always_comb
    begin
        adv[LAST] = ~v_reg[LAST] | out_ready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            adv[i] = ~v_reg[i] | adv[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= (i == 0) ? in_valid : v_reg[i-1];
                end
            end
        end
    end

    // Prep: numerator mag*2^(F+1) + L over divisor 2L
    always_ff @(posedge clk)
    begin
        logic [NUM_W-1:0] num;
        if (adv[0])
        begin
            dvs_reg[0]  <= {in_root, 1'b0};
            side_reg[0] <= in_side;
            for (int c = 0; c < 3; c++)
            begin
                num = {1'b0, in_side.mag[c], QUO_W'(0)} + NUM_W'(in_root);
                prem_reg[0][c] <= DIVR_W'(num >> QUO_W);
                low_reg[0][c]  <= num[QUO_W-1:0];
                quo_reg[0][c]  <= '0;
            end
        end
    end

    for (genvar k = 1; k <= QUO_W; k++)
    begin : g_step
        logic [2:0][DIVR_W-1:0] prem_next;
        logic [2:0][QUO_W-1:0]  quo_next;
        logic [DIVR_W:0]        shifted [3];

        // Shift in next numerator bit, subtract divisor if it fits
        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                shifted[c] = {prem_reg[k-1][c], low_reg[k-1][c][QUO_W-1]};
                if (shifted[c] >= {1'b0, dvs_reg[k-1]})
                begin
                    prem_next[c] = DIVR_W'(shifted[c] - {1'b0, dvs_reg[k-1]});
                    quo_next[c]  = {quo_reg[k-1][c][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    prem_next[c] = shifted[c][DIVR_W-1:0];
                    quo_next[c]  = {quo_reg[k-1][c][QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                dvs_reg[k]  <= dvs_reg[k-1];
                side_reg[k] <= side_reg[k-1];
                prem_reg[k] <= prem_next;
                quo_reg[k]  <= quo_next;
                for (int c = 0; c < 3; c++)
                begin
                    low_reg[k][c] <= {low_reg[k-1][c][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    // Output stage: apply signs, force zero vector when degenerate
    always_ff @(posedge clk)
    begin
        logic [2:0][NORMAL_WIDTH-1:0] comp;
        if (adv[LAST])
        begin
            for (int c = 0; c < 3; c++)
            begin
                comp[c] = NORMAL_WIDTH'(quo_reg[QUO_W][c]);
                if (side_reg[QUO_W].degen)
                begin
                    comp[c] = '0;
                end
                else if (side_reg[QUO_W].neg[c])
                begin
                    comp[c] = -comp[c];
                end
            end
            out_reg.normal_x   <= comp[0];
            out_reg.normal_y   <= comp[1];
            out_reg.normal_z   <= comp[2];
            out_reg.degenerate <= side_reg[QUO_W].degen;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[LAST];
    assign out_data  = out_reg;

endmodule

@@ design/unit_triangle_normal_core.sv @@
// Unit triangle normal, top level: front pipeline (edges, cross product,
// normalisation, squares) feeding utn_isqrt and utn_div. Depends on utn_pkg.
//
//   channel | signals                          | payload
//   --------+----------------------------------+-----------------------
//   input   | in_valid / in_ready / in_data    | tri_in_t  (A, B, pivot)
//   output  | out_valid / out_ready / out_data | tri_out_t (unit normal)
//
// One transaction accepted per cycle unless a stalled output has filled the
// pipeline; 9 front stages, one stage per root bit of the square root (31) and
// one per quotient bit of the divide plus prep and output stages (17).
// Every stage moves when it is empty or its successor moves, so bubbles close
// up and input keeps flowing while a result waits at the output.
// Reset clears only valid bits; no state is kept between triangles.
module unit_triangle_normal_core
    import utn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  tri_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output tri_out_t out_data
);

    localparam int FRONT_STAGES = 9;
    localparam int FLAST        = FRONT_STAGES - 1;

    logic [FRONT_STAGES-1:0] fv_reg;
    logic [FRONT_STAGES-1:0] fadv;
    logic                    sq_ready;

    logic signed [DIFF_W-1:0]  du_reg [3];
    logic signed [DIFF_W-1:0]  dv_reg [3];
    logic signed [PROD_W-1:0]  prod_reg [6];
    logic signed [CROSS_W-1:0] cross_reg [3];
    logic [MAG_W-1:0]          mag4_reg [3];
    logic [2:0]                neg4_reg;
    logic [MAG_W-1:0]          mag5_reg [3];
    logic [2:0]                neg5_reg;
    logic [MAG_W-1:0]          big5_reg;
    logic [MAG_W-1:0]          mag6_reg [3];
    logic [2:0]                neg6_reg;
    logic                      degen6_reg;
    logic [POS_W-1:0]          pos6_reg;
    nrm_side_t                 side7_reg;
    nrm_side_t                 side8_reg;
    logic [SQ_W-1:0]           sq8_reg [3];
    nrm_side_t                 side9_reg;
    logic [SUM_W-1:0]          sum9_reg;

    logic                      sq_out_valid;
    logic                      div_ready;
    logic [ROOT_W-1:0]         root;
    nrm_side_t                 root_side;

    // Front pipeline handshake
    always_comb
    begin
        fadv[FLAST] = ~fv_reg[FLAST] | sq_ready;
        for (int i = FLAST - 1; i >= 0; i--)
        begin
            fadv[i] = ~fv_reg[i] | fadv[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < FRONT_STAGES; i++)
            begin
                if (fadv[i])
                begin
                    fv_reg[i] <= (i == 0) ? in_valid : fv_reg[i-1];
                end
            end
        end
    end

    // Stage 1: edge vectors U = A - C, V = B - C
    always_ff @(posedge clk)
    begin
        if (fadv[0])
        begin
            du_reg[0] <= DIFF_W'(in_data.point_a_x) - DIFF_W'(in_data.pivot_x);
            du_reg[1] <= DIFF_W'(in_data.point_a_y) - DIFF_W'(in_data.pivot_y);
            du_reg[2] <= DIFF_W'(in_data.point_a_z) - DIFF_W'(in_data.pivot_z);
            dv_reg[0] <= DIFF_W'(in_data.point_b_x) - DIFF_W'(in_data.pivot_x);
            dv_reg[1] <= DIFF_W'(in_data.point_b_y) - DIFF_W'(in_data.pivot_y);
            dv_reg[2] <= DIFF_W'(in_data.point_b_z) - DIFF_W'(in_data.pivot_z);
        end
    end

    // Stage 2: six partial products of the cross product
    always_ff @(posedge clk)
    begin
        if (fadv[1])
        begin
            prod_reg[0] <= du_reg[1] * dv_reg[2];
            prod_reg[1] <= du_reg[2] * dv_reg[1];
            prod_reg[2] <= du_reg[2] * dv_reg[0];
            prod_reg[3] <= du_reg[0] * dv_reg[2];
            prod_reg[4] <= du_reg[0] * dv_reg[1];
            prod_reg[5] <= du_reg[1] * dv_reg[0];
        end
    end

    // Stage 3: cross product components
    always_ff @(posedge clk)
    begin
        if (fadv[2])
        begin
            for (int c = 0; c < 3; c++)
            begin
                cross_reg[c] <= CROSS_W'(prod_reg[2*c]) - CROSS_W'(prod_reg[2*c+1]);
            end
        end
    end

    // Stage 4: sign and magnitude
    always_ff @(posedge clk)
    begin
        if (fadv[3])
        begin
            for (int c = 0; c < 3; c++)
            begin
                neg4_reg[c] <= cross_reg[c][CROSS_W-1];
                mag4_reg[c] <= cross_reg[c][CROSS_W-1] ? MAG_W'(-cross_reg[c])
                                                       : MAG_W'(cross_reg[c]);
            end
        end
    end

    // Stage 5: largest magnitude
    always_ff @(posedge clk)
    begin
        logic [MAG_W-1:0] big;
        if (fadv[4])
        begin
            big = (mag4_reg[1] > mag4_reg[0]) ? mag4_reg[1] : mag4_reg[0];
            big = (mag4_reg[2] > big) ? mag4_reg[2] : big;
            big5_reg <= big;
            mag5_reg <= mag4_reg;
            neg5_reg <= neg4_reg;
        end
    end

    // Stage 6: leading one position of the largest magnitude
    always_ff @(posedge clk)
    begin
        logic [POS_W-1:0] pos;
        if (fadv[5])
        begin
            pos = '0;
            for (int j = 0; j < MAG_W; j++)
            begin
                if (big5_reg[j])
                begin
                    pos = POS_W'(j);
                end
            end
            pos6_reg   <= pos;
            degen6_reg <= (big5_reg == '0);
            mag6_reg   <= mag5_reg;
            neg6_reg   <= neg5_reg;
        end
    end

    // Stage 7: scale so the largest lands at bit SCALE_TOP (truncating)
    always_ff @(posedge clk)
    begin
        logic [MAG_W+SCALE_TOP-1:0] wide;
        if (fadv[6])
        begin
            for (int c = 0; c < 3; c++)
            begin
                wide = {mag6_reg[c], SCALE_TOP'(0)} >> pos6_reg;
                side7_reg.mag[c] <= wide[NMAG_W-1:0];
            end
            side7_reg.neg   <= neg6_reg;
            side7_reg.degen <= degen6_reg;
        end
    end

    // Stage 8: squares
    always_ff @(posedge clk)
    begin
        if (fadv[7])
        begin
            for (int c = 0; c < 3; c++)
            begin
                sq8_reg[c] <= side7_reg.mag[c] * side7_reg.mag[c];
            end
            side8_reg <= side7_reg;
        end
    end

    // Stage 9: sum of squares
    always_ff @(posedge clk)
    begin
        if (fadv[8])
        begin
            sum9_reg  <= SUM_W'(sq8_reg[0]) + SUM_W'(sq8_reg[1]) + SUM_W'(sq8_reg[2]);
            side9_reg <= side8_reg;
        end
    end

    utn_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fv_reg[FLAST]),
        .in_ready  (sq_ready),
        .in_sum    (sum9_reg),
        .in_side   (side9_reg),
        .out_valid (sq_out_valid),
        .out_ready (div_ready),
        .out_root  (root),
        .out_side  (root_side)
    );

    utn_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_out_valid),
        .in_ready  (div_ready),
        .in_root   (root),
        .in_side   (root_side),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign in_ready = fadv[0];

endmodule

@@ design/utn_checker.sv @@
// Unit triangle normal: port-level assertions and their bind to the top level.
// Depends on utn_pkg and unit_triangle_normal_core.
module utn_assertions
    import utn_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     out_valid,
    input logic     out_ready,
    input tri_out_t out_data
);

    localparam logic signed [NORMAL_WIDTH-1:0] ONE  = NORMAL_WIDTH'(1) << NORMAL_FRAC_BITS;
    localparam logic signed [NORMAL_WIDTH-1:0] MONE = -ONE;
    localparam logic signed [NORMAL_WIDTH-1:0] HALF = NORMAL_WIDTH'(1) << (NORMAL_FRAC_BITS - 1);
    localparam logic signed [NORMAL_WIDTH-1:0] MHALF = -HALF;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Degenerate triangles give the zero vector
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.degenerate |->
            out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.normal_z == '0)
        else $error("degenerate result not zero");

    // Components stay within the unit range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            out_data.normal_x <= ONE && out_data.normal_x >= MONE &&
            out_data.normal_y <= ONE && out_data.normal_y >= MONE &&
            out_data.normal_z <= ONE && out_data.normal_z >= MONE)
        else $error("normal component out of range");

    // A true normal has at least one component of magnitude a half or more
    a_unit_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.degenerate |->
            out_data.normal_x >= HALF || out_data.normal_x <= MHALF ||
            out_data.normal_y >= HALF || out_data.normal_y <= MHALF ||
            out_data.normal_z >= HALF || out_data.normal_z <= MHALF)
        else $error("normal too short");

endmodule

bind unit_triangle_normal_core utn_assertions u_utn_assertions (.*);

@@ tb/utn_checker.sv @@
// Unit triangle normal checker: watches both channels, predicts each normal
// from the accepted triangle and compares. Depends on utn_pkg.
module utn_checker
    import utn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_ready,
    input  tri_in_t  in_data,
    input  logic     out_valid,
    input  logic     out_ready,
    input  tri_out_t out_data,
    output int       fail_count,
    output int       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    tri_out_t normal_queue[$];

    // integer square root, floor
    function automatic longint unsigned root_floor(longint unsigned s);
        longint unsigned rem, root, b;
        rem  = s;
        root = 0;
        b    = 64'd1 << 62;
        while (b > rem)
            b >>= 2;
        while (b != 0)
        begin
            if (rem >= root + b)
            begin
                rem  -= root + b;
                root  = (root >> 1) + b;
            end
            else
                root >>= 1;
            b >>= 2;
        end
        return root;
    endfunction

    // expected unit normal for one triangle
    function automatic tri_out_t unit_normal(tri_in_t t);
        longint u[3], v[3], n[3];
        longint unsigned m[3], big, s, len, q;
        int top;
        tri_out_t r;
        u[0] = longint'(t.point_a_x) - longint'(t.pivot_x);
        u[1] = longint'(t.point_a_y) - longint'(t.pivot_y);
        u[2] = longint'(t.point_a_z) - longint'(t.pivot_z);
        v[0] = longint'(t.point_b_x) - longint'(t.pivot_x);
        v[1] = longint'(t.point_b_y) - longint'(t.pivot_y);
        v[2] = longint'(t.point_b_z) - longint'(t.pivot_z);
        n[0] = u[1] * v[2] - u[2] * v[1];
        n[1] = u[2] * v[0] - u[0] * v[2];
        n[2] = u[0] * v[1] - u[1] * v[0];
        big = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (n[i] < 0) ? -n[i] : n[i];
            if (m[i] > big)
                big = m[i];
        end
        r = '0;
        if (big == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        top = -1;
        while (big != 0)
        begin
            top++;
            big >>= 1;
        end
        for (int i = 0; i < 3; i++)
            m[i] = (top > SCALE_TOP) ? m[i] >> (top - SCALE_TOP) : m[i] << (SCALE_TOP - top);
        s   = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = root_floor(s);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << (NORMAL_FRAC_BITS + 1)) + len) / (len << 1);
            if (n[i] < 0)
                q = -q;
            case (i)
                0: r.normal_x = q[NORMAL_WIDTH-1:0];
                1: r.normal_y = q[NORMAL_WIDTH-1:0];
                default: r.normal_z = q[NORMAL_WIDTH-1:0];
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // capture triangles and compare normals on each transaction
    always @(posedge clk)
    begin
        tri_out_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                normal_queue.push_back(unit_normal(in_data));
            if (out_valid && out_ready)
            begin
                if (normal_queue.size() == 0)
                    report_mismatch("unexpected transaction", 0, 0);
                else
                begin
                    want = normal_queue.pop_front();
                    if (out_data.normal_x !== want.normal_x)
                        report_mismatch("normal_x", out_data.normal_x, want.normal_x);
                    if (out_data.normal_y !== want.normal_y)
                        report_mismatch("normal_y", out_data.normal_y, want.normal_y);
                    if (out_data.normal_z !== want.normal_z)
                        report_mismatch("normal_z", out_data.normal_z, want.normal_z);
                    if (out_data.degenerate !== want.degenerate)
                        report_mismatch("degenerate", out_data.degenerate, want.degenerate);
                end
            end
            pending = normal_queue.size();
        end
    end

endmodule

@@ tb/unit_triangle_normal_core_test.sv @@
// Unit triangle normal testbench top: clock, reset, triangle stimulus and
// verdict. Depends on utn_pkg, utn_checker and unit_triangle_normal_core.
module unit_triangle_normal_core_test;
    import utn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 57;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    tri_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    tri_out_t out_data;
    int       fail_count;
    int       pending;
    bit       calm;

    unit_triangle_normal_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    utn_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($urandom_range(0, 15) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // send one triangle; valid held until the transaction completes
    task automatic send_triangle(tri_in_t t);
        while (!calm && $urandom_range(0, 99) < 31)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_data  <= t;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic tri_in_t make_tri(int kind);
        tri_in_t t;
        t = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
        case (kind)
            0: t = t;
            1:
            begin
                t.point_a_x = rand_coord(); t.point_a_y = rand_coord();
                t.point_a_z = rand_coord(); t.point_b_x = rand_coord();
                t.point_b_y = rand_coord(); t.point_b_z = rand_coord();
                t.pivot_x = rand_coord(); t.pivot_y = rand_coord();
                t.pivot_z = rand_coord();
            end
            2:
            begin
                // collinear: B = pivot + k*(A - pivot) in small steps
                t.pivot_x = 16'($urandom_range(0, 2000) - 1000);
                t.pivot_y = 16'($urandom_range(0, 2000) - 1000);
                t.pivot_z = 16'($urandom_range(0, 2000) - 1000);
                t.point_a_x = t.pivot_x + 16'($urandom_range(0, 200) - 100);
                t.point_a_y = t.pivot_y + 16'($urandom_range(0, 200) - 100);
                t.point_a_z = t.pivot_z + 16'($urandom_range(0, 200) - 100);
                t.point_b_x = t.pivot_x + 16'(3) * (t.point_a_x - t.pivot_x);
                t.point_b_y = t.pivot_y + 16'(3) * (t.point_a_y - t.pivot_y);
                t.point_b_z = t.pivot_z + 16'(3) * (t.point_a_z - t.pivot_z);
            end
            default:
            begin
                // tiny triangle near a random pivot
                t.point_a_x = t.pivot_x + 16'($urandom_range(0, 4) - 2);
                t.point_a_y = t.pivot_y + 16'($urandom_range(0, 4) - 2);
                t.point_a_z = t.pivot_z + 16'($urandom_range(0, 4) - 2);
                t.point_b_x = t.pivot_x + 16'($urandom_range(0, 4) - 2);
                t.point_b_y = t.pivot_y + 16'($urandom_range(0, 4) - 2);
                t.point_b_z = t.pivot_z + 16'($urandom_range(0, 4) - 2);
            end
        endcase
        return t;
    endfunction

    // receiver stalls
    always @(negedge clk)
        out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 31);

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        tri_in_t t;
        int wait_cycles;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        calm     = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, coincident, axis-aligned, largest cross product
        send_triangle('0);
        send_triangle({9{16'sh7fff}});
        send_triangle({9{16'sh8000}});
        t = '0; t.point_a_x = 16'sd4096; t.point_b_y = 16'sd4096;
        send_triangle(t);
        t = '0; t.point_a_y = 16'sd4096; t.point_b_x = 16'sd4096;
        send_triangle(t);
        t = '0; t.point_a_y = 16'sd1; t.point_b_z = 16'sd1;
        send_triangle(t);
        t = '0; t.point_a_z = 16'sd1; t.point_b_x = 16'sd1;
        send_triangle(t);
        t = '0; t.point_a_x = 16'sh7fff; t.point_b_y = 16'sh7fff;
        t.pivot_x = 16'sh8000; t.pivot_y = 16'sh8000;
        send_triangle(t);
        t = {16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
             16'sh8000, 16'sh7fff, 16'sh8000};
        send_triangle(t);
        t = '0; t.point_a_x = 16'sd1; t.point_a_y = 16'sd1; t.point_a_z = 16'sd1;
        t.point_b_x = 16'sd2; t.point_b_y = 16'sd2; t.point_b_z = 16'sd2;
        send_triangle(t);
        t = '0; t.point_a_x = 16'sd3; t.point_b_y = 16'sd4; t.point_a_z = 16'sd1;
        send_triangle(t);
        for (int i = 0; i < 4; i++)
            send_triangle(make_tri(2));
        in_valid <= 1'b0;

        // hold off until every expected normal has arrived
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 100000)
        begin
            @(negedge clk);
            wait_cycles++;
        end

        // random part, with one back-to-back stretch
        for (int i = 0; i < 1300; i++)
        begin
            calm = (i >= 500 && i < 700);
            send_triangle(make_tri($urandom_range(0, 9) < 2 ? $urandom_range(2, 3)
                                                             : $urandom_range(0, 1)));
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 100000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 10) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
design/utn_pkg.sv
design/utn_isqrt.sv
design/utn_div.sv
design/unit_triangle_normal_core.sv
design/utn_checker.sv
tb/utn_checker.sv
tb/unit_triangle_normal_core_test.sv
